// ===== design/sbfcd_pkg.sv =====
// ============================================================================
// sbfcd_pkg
// Shared constants and types of the seven-bit frame checked decoder.
// ============================================================================
`default_nettype none

package sbfcd_pkg;

  // Frame layout
  localparam int unsigned PosW    = 5;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PartW   = 7;
  localparam int unsigned NumWords = 7;
  localparam int unsigned NumKept  = 5;
  localparam int unsigned KIdxW    = 3;

  localparam logic [PosW-1:0] PosFirst     = 5'd0;
  localparam logic [PosW-1:0] PosMsbHigh   = 5'd2;
  localparam logic [PosW-1:0] PosMsbLow    = 5'd3;
  localparam logic [PosW-1:0] PosHighFirst = 5'd4;
  localparam logic [PosW-1:0] PosHighKeptEnd = 5'd9;   // first high part past the kept words
  localparam logic [PosW-1:0] PosLowFirst  = 5'd11;
  localparam logic [PosW-1:0] PosLowKeptEnd  = 5'd16;  // first low part past the kept words
  localparam logic [PosW-1:0] PosLast      = 5'd17;
  localparam logic [PosW-1:0] FrameLen     = 5'd18;

  localparam logic [3:0] WeightTop = 4'd10;
  localparam logic [3:0] WeightLow = 4'd5;

  // One decoded result
  typedef struct packed {
    logic                          frame_ok;
    logic [WordW-1:0]              good_frames;
    logic [NumKept-1:0][WordW-1:0] words;   // word 0 in the lowest bits
  } result_t;

  // Status of the frame core seen by the top level
  typedef struct packed {
    logic             has_result;
    logic [PosW-1:0]  byte_index;
    logic [WordW-1:0] good_count;
  } core_status_t;

endpackage

`default_nettype wire

// ===== design/sbfcd_in_stage.sv =====
// ============================================================================
// sbfcd_in_stage
// Input register: holds one received byte and its start flag.
// ============================================================================
`default_nettype none

module sbfcd_in_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output      logic                       ready_o,
  input  wire logic [sbfcd_pkg::ByteW-1:0] byte_i,
  input  wire logic                       start_i,
  input  wire logic                       advance_i,
  output      logic                       valid_o,
  output      logic [sbfcd_pkg::ByteW-1:0] byte_o,
  output      logic                       start_o
);

  logic                        valid_q, valid_d;
  logic [sbfcd_pkg::ByteW-1:0] byte_q;
  logic                        start_q;
  logic                        take;

  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q  <= byte_i;
      start_q <= start_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign start_o = start_q;

endmodule

`default_nettype wire

// ===== design/sbfcd_frame_core.sv =====
// ============================================================================
// sbfcd_frame_core
// Frame position tracking, part stores, running checksums and result forming.
// ============================================================================
`default_nettype none

module sbfcd_frame_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         advance_i,
  input  wire logic [sbfcd_pkg::ByteW-1:0]  byte_i,
  input  wire logic                         start_i,
  output      sbfcd_pkg::result_t           result_o,
  output      sbfcd_pkg::core_status_t      status_o
);

  logic [sbfcd_pkg::PosW-1:0]  idx_q, idx_d, pos;
  logic [sbfcd_pkg::PartW-1:0] msbh_q, msbh_d, msbl_q, msbl_d;
  logic [sbfcd_pkg::PartW-1:0] hi_part_q [sbfcd_pkg::NumWords];
  logic [sbfcd_pkg::PartW-1:0] lo_part_q [sbfcd_pkg::NumWords-1];
  logic [sbfcd_pkg::WordW-1:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [sbfcd_pkg::NumKept-1:0][sbfcd_pkg::WordW-1:0] kept_q, kept_d, word_new;
  logic [sbfcd_pkg::WordW-1:0] good_q, good_d;

  logic [sbfcd_pkg::PartW-1:0] part;
  logic [sbfcd_pkg::KIdxW-1:0] hk, lk, ak;
  logic                        in_frame, is_hi, is_lo, acc_hi, acc_lo, last;
  logic [sbfcd_pkg::ByteW-1:0] acc_byte;
  logic [3:0]                  weight;
  logic [11:0]                 product;
  logic [sbfcd_pkg::WordW-1:0] word5, word6;
  logic                        ok;

  assign pos  = start_i ? sbfcd_pkg::PosFirst : idx_q;
  assign part = byte_i[sbfcd_pkg::PartW-1:0];
  assign hk   = sbfcd_pkg::KIdxW'(pos - sbfcd_pkg::PosHighFirst);
  assign lk   = sbfcd_pkg::KIdxW'(pos - sbfcd_pkg::PosLowFirst);

  assign in_frame = pos < sbfcd_pkg::FrameLen;
  assign is_hi    = (pos >= sbfcd_pkg::PosHighFirst) && (pos < sbfcd_pkg::PosLowFirst);
  assign is_lo    = (pos >= sbfcd_pkg::PosLowFirst) && in_frame;
  assign acc_hi   = (pos >= sbfcd_pkg::PosHighFirst) && (pos < sbfcd_pkg::PosHighKeptEnd);
  assign acc_lo   = (pos >= sbfcd_pkg::PosLowFirst) && (pos < sbfcd_pkg::PosLowKeptEnd);
  assign last     = pos == sbfcd_pkg::PosLast;

  // Byte of a kept word with its top bit restored, and its checksum weight
  assign ak       = acc_hi ? hk : lk;
  assign acc_byte = acc_hi ? {msbh_q[ak], part} : {msbl_q[ak], part};
  assign weight   = acc_hi ? (sbfcd_pkg::WeightTop - {1'b0, hk})
                           : (sbfcd_pkg::WeightLow - {1'b0, lk});
  assign product  = acc_byte * weight;

  always_comb begin
    for (int k = 0; k < sbfcd_pkg::NumKept; k++) begin
      word_new[k] = {msbh_q[k], hi_part_q[k], msbl_q[k], lo_part_q[k]};
    end
  end

  assign word5 = {msbh_q[5], hi_part_q[5], msbl_q[5], lo_part_q[5]};
  assign word6 = {msbh_q[6], hi_part_q[6], msbl_q[6], part};
  assign ok    = (sum_a_q == word5) && (sum_b_q == word6);

  always_comb begin
    idx_d   = idx_q;
    msbh_d  = msbh_q;
    msbl_d  = msbl_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    kept_d  = kept_q;
    good_d  = good_q;
    if (in_frame) begin
      idx_d = pos + 1'b1;
      if (pos == sbfcd_pkg::PosFirst) begin
        sum_a_d = '0;
        sum_b_d = '0;
      end
      if (pos == sbfcd_pkg::PosMsbHigh) begin
        msbh_d = part;
      end
      if (pos == sbfcd_pkg::PosMsbLow) begin
        msbl_d = part;
      end
      if (acc_hi || acc_lo) begin
        sum_a_d = sum_a_q + {8'd0, acc_byte};
        sum_b_d = sum_b_q + {4'd0, product};
      end
      if (last && ok) begin
        kept_d = word_new;
        good_d = good_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      msbh_q  <= '0;
      msbl_q  <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      kept_q  <= '0;
      good_q  <= '0;
    end else if (advance_i) begin
      idx_q   <= idx_d;
      msbh_q  <= msbh_d;
      msbl_q  <= msbl_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      kept_q  <= kept_d;
      good_q  <= good_d;
    end
  end

  // Part stores; the last low part is used straight from the input
  always_ff @(posedge clk_i) begin
    if (advance_i && is_hi) begin
      hi_part_q[hk] <= part;
    end
    if (advance_i && is_lo && !last) begin
      lo_part_q[lk] <= part;
    end
  end

  assign result_o.frame_ok    = ok;
  assign result_o.good_frames = good_d;
  assign result_o.words       = kept_d;

  assign status_o.has_result = in_frame && last;
  assign status_o.byte_index = idx_q;
  assign status_o.good_count = good_q;

endmodule

`default_nettype wire

// ===== design/sbfcd_out_stage.sv =====
// ============================================================================
// sbfcd_out_stage
// Result register on the master side of the decoder.
// ============================================================================
`default_nettype none

module sbfcd_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire sbfcd_pkg::result_t result_i,
  input  wire logic               ready_i,
  output      logic               free_o,
  output      logic               valid_o,
  output      sbfcd_pkg::result_t result_o
);

  logic               valid_q, valid_d;
  sbfcd_pkg::result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== design/seven_bit_frame_checked_decoder.sv =====
// ============================================================================
// seven_bit_frame_checked_decoder
// Decodes 18-byte frames of 7-bit parts into checked 16-bit speed words.
// ============================================================================
// Usage:
//   Slave side: one received byte per transfer on s_axis_tdata_i; assert
//   s_axis_tuser_i on the first byte of a frame to restart the position.
//   Bytes 0 and 1 are skipped, bytes 2/3 carry the top bits, bytes 4..17 the
//   7-bit parts. Bytes past the 18th are dropped until the next start.
//   Master side: one transfer per frame, on its last byte, with the frame
//   check flag in tuser and the five kept words plus the good-frame count in
//   tdata. Kept words change only when both checksums match.
//   Throughput: one byte per cycle while no last byte is held (see Stall);
//   each byte passes the input register and the frame core, whose running
//   sums add one weighted byte per cycle while bytes advance.
//   Result path: input register, then result register, then m_axis_tvalid_o.
//   Stall: while the result register waits, bytes that end no frame keep
//   flowing; only a frame's last byte holds in the input register.
//   Reset: position, top bits, sums, kept words and count clear to zero.
// ============================================================================
`default_nettype none

module seven_bit_frame_checked_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser_i,   // [0] frame_start
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [95:0] m_axis_tdata_o,   // wheel0_speed, wheel1_speed, wheel2_speed,
                                             // wheel3_speed, spinner_speed, good_frames
  output      logic        m_axis_tuser_o    // [0] frame_ok
);

  logic                        s1_valid, s1_start, advance, load, out_free;
  logic [sbfcd_pkg::ByteW-1:0] s1_byte;
  sbfcd_pkg::result_t          core_result, out_result;
  sbfcd_pkg::core_status_t     status;

  // Advance the held byte unless it ends a frame and the result register is full
  assign advance = s1_valid && (!status.has_result || out_free);
  assign load    = advance && status.has_result;

  sbfcd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .byte_i    (s_axis_tdata_i),
    .start_i   (s_axis_tuser_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .byte_o    (s1_byte),
    .start_o   (s1_start)
  );

  sbfcd_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (s1_byte),
    .start_i   (s1_start),
    .result_o  (core_result),
    .status_o  (status)
  );

  sbfcd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .result_i (core_result),
    .ready_i  (m_axis_tready_i),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_result)
  );

  // Pack the kept words from word 0 up, then the count
  assign m_axis_tdata_o = {out_result.good_frames, out_result.words};
  assign m_axis_tuser_o = out_result.frame_ok;

  // Only a frame's last byte may be held back
  a_hold_only_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !advance) |-> status.has_result)
    else $error("input register held a byte that ends no frame");

  // The good-frame count moves only with a matching frame's result
  a_count_on_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(status.good_count) |-> $past(load && core_result.frame_ok))
    else $error("good-frame count changed without a matching frame");

  // The frame position saturates at the frame length
  a_index_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.byte_index <= sbfcd_pkg::FrameLen)
    else $error("frame position ran past the frame length");

endmodule

`default_nettype wire
